@@ rtl/adam_optimizer_update_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Adam update block
// Shorthands for clocked implications with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ADAM_OPTIMIZER_UPDATE_ASSERT_SVH
`define ADAM_OPTIMIZER_UPDATE_ASSERT_SVH

// Same-cycle implication.
`define ADAM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ADAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/adam_pkg.sv @@
// ----------------------------------------------------------------------------
// adam_pkg
// Types, constants and register codes shared by the Adam update block.
// ----------------------------------------------------------------------------
`default_nettype none

package adam_pkg;

  localparam int IDX_W      = 12;
  localparam int DATA_W     = 32;
  localparam int LR_W       = 24;
  localparam int BETA_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int NUM_PARAMS_DEF = 4096;

  localparam logic [LR_W-1:0]   LR_RST    = 24'd16777;
  localparam logic [BETA_W-1:0] B1_RST    = 16'd58982;
  localparam logic [BETA_W-1:0] B2_RST    = 16'd65470;
  localparam logic [BETA_W-1:0] BATCH_RST = 16'd1;
  localparam logic [BETA_W-1:0] EPS_RST   = 16'd1;

  localparam logic [16:0] Q16_ONE = 17'h10000;
  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  localparam logic [6:0] ITER_DIV_STEPS  = 7'd64;
  localparam logic [6:0] ITER_SQRT_STEPS = 7'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEARNING_RATE = 3'd0,
    CFG_BETA_FIRST    = 3'd1,
    CFG_BETA_SECOND   = 3'd2,
    CFG_BATCH_SIZE    = 3'd3,
    CFG_EPSILON       = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    ITER_DIV  = 1'b0,
    ITER_SQRT = 1'b1
  } iter_mode_t;

  typedef struct packed {
    logic        [IDX_W-1:0]  param_index;
    logic signed [DATA_W-1:0] gradient;
    logic signed [DATA_W-1:0] weight_in;
  } in_item_t;

  typedef struct packed {
    logic        [IDX_W-1:0]  out_index;
    logic signed [DATA_W-1:0] weight_out;
    logic                     saturated;
  } out_item_t;

  typedef struct packed {
    logic        start;
    iter_mode_t  mode;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } iter_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] result;
  } iter_rsp_t;

endpackage

`default_nettype wire

@@ rtl/adam_optimizer_update.sv @@
// ----------------------------------------------------------------------------
// adam_optimizer_update
// Adam weight update for one parameter per beat, Q16.16 fixed point, with
// per-parameter moment RAMs and bias correction by running beta powers.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_valid/in_stall   adam_pkg::in_item_t
//   out_     output     out_valid/out_stall adam_pkg::out_item_t
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// After reset the block sweeps both moment RAMs to zero, one entry per cycle,
// for NUM_PARAMS entries, holding in_stall high; configuration is taken then too.
// An in-range beat keeps in_stall high until its result is loaded; its time is
// set by the shared divide/square-root unit: three 64-bit divides and one
// 32-step root (the last two skipped when the corrected second moment plus
// epsilon is zero). An out-of-range index goes straight to the output step.
// A finished result sits in the output register while a new beat is accepted;
// out_stall only holds the block at its final step.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adam_optimizer_update_assert.svh"

module adam_optimizer_update #(
  parameter int NUM_PARAMS = adam_pkg::NUM_PARAMS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire adam_pkg::in_item_t                   in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output adam_pkg::out_item_t                       out_data,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [adam_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [adam_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int AW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;

  // The sequencer walks one beat through read, moment update, write-back,
  // then the bias-corrected step through the shared iterative unit.
  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7,
    ST_WB, ST_MH, ST_VH, ST_S, ST_RDIV, ST_SQRT, ST_T, ST_D, ST_RES, ST_OUT
  } state_t;

  state_t state_r;
  logic [AW-1:0] clr_cnt_r;

  // Configuration and bias-correction state.
  logic [adam_pkg::LR_W-1:0]   lr_r;
  logic [adam_pkg::BETA_W-1:0] b1_r;
  logic [adam_pkg::BETA_W-1:0] b2_r;
  logic [adam_pkg::BETA_W-1:0] batch_r;
  logic [adam_pkg::BETA_W-1:0] eps_r;
  logic [adam_pkg::BETA_W-1:0] bfp_r;
  logic [adam_pkg::BETA_W-1:0] bsp_r;
  logic [adam_pkg::BETA_W-1:0] upd_cnt_r;

  // Per-beat working registers.
  logic [adam_pkg::IDX_W-1:0]   idx_r;
  logic signed [31:0]           g_r;
  logic signed [31:0]           w_r;
  logic                         in_range_r;
  logic                         sat_r;
  logic signed [31:0]           m_old_r;
  logic [31:0]                  v_old_r;
  logic signed [65:0]           pa_r;
  logic signed [65:0]           pb_r;
  logic signed [31:0]           m_r;
  logic [31:0]                  gsq_r;
  logic [31:0]                  v_r;
  logic signed [31:0]           mh_r;
  logic [31:0]                  vh_r;
  logic [31:0]                  r_r;
  logic [31:0]                  t_r;
  logic signed [31:0]           res_r;
  logic                         out_valid_r;
  adam_pkg::out_item_t          out_data_r;

  // RAM ports.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   m_wdata;
  logic [31:0]   v_wdata;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   m_rdata;
  logic [31:0]   v_rdata;

  adam_pkg::iter_req_t iter_req;
  adam_pkg::iter_rsp_t iter_rsp;

  // Datapath combinational terms.
  logic               in_acc;
  logic               cfg_wr;
  logic               in_range;
  logic [16:0]        c_b1;
  logic [16:0]        c_b2;
  logic [16:0]        c_p1;
  logic [16:0]        c_p2;
  logic signed [65:0] pab_sum;
  logic signed [65:0] m_sh;
  logic [32:0]        m_sat;
  logic [32:0]        m_abs;
  logic [32:0]        s_sum;
  logic [31:0]        s_val;
  logic [55:0]        t_prod;
  logic signed [65:0] d_sh;
  logic signed [65:0] diff;
  logic [32:0]        res_sat;
  logic [63:0]        q;
  logic [31:0]        q_neg;
  logic [15:0]        cnt_inc;
  logic [31:0]        bfp_prod;
  logic [31:0]        bsp_prod;

  // Saturate a wide signed value to 32 bits; bit 32 of the result flags it.
  function automatic logic [32:0] sat_s32(input logic signed [65:0] x);
    logic ovf_pos;
    logic ovf_neg;
    ovf_pos = !x[65] && (|x[64:31]);
    ovf_neg = x[65] && !(&x[64:31]);
    if (ovf_pos) begin
      return {1'b1, adam_pkg::S32_MAX};
    end else if (ovf_neg) begin
      return {1'b1, adam_pkg::S32_MIN};
    end
    return {1'b0, x[31:0]};
  endfunction

  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign in_range  = (32'(in_data.param_index) < 32'(NUM_PARAMS));

  always_comb begin
    c_b1    = 17'(adam_pkg::Q16_ONE - {1'b0, b1_r});
    c_b2    = 17'(adam_pkg::Q16_ONE - {1'b0, b2_r});
    c_p1    = 17'(adam_pkg::Q16_ONE - {1'b0, bfp_r});
    c_p2    = 17'(adam_pkg::Q16_ONE - {1'b0, bsp_r});
    pab_sum = pa_r + pb_r;
    m_sh    = pab_sum >>> 16;
    m_sat   = sat_s32(m_sh);
    // Magnitude of the new first moment, for the unsigned divider.
    m_abs   = m_r[31] ? (33'd0 - {m_r[31], m_r}) : {1'b0, m_r};
    s_sum   = {1'b0, vh_r} + {17'b0, eps_r};
    s_val   = s_sum[32] ? 32'hFFFF_FFFF : s_sum[31:0];
    t_prod  = 56'(lr_r) * 56'(r_r);
    d_sh    = pa_r >>> 24;
    diff    = {{34{w_r[31]}}, w_r} - d_sh;
    res_sat = sat_s32(diff);
    q       = iter_rsp.result;
    q_neg   = 32'd0 - q[31:0];
    cnt_inc = upd_cnt_r + 16'd1;
    bfp_prod = 32'(bfp_r) * 32'(b1_r);
    bsp_prod = 32'(bsp_r) * 32'(b2_r);
  end

  // RAM access: the sweep after reset writes zeros, the write-back state
  // stores both new moments, and reads follow the incoming index.
  always_comb begin
    ram_we    = (state_r == ST_CLEAR) || (state_r == ST_WB);
    ram_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : AW'(idx_r);
    m_wdata   = (state_r == ST_CLEAR) ? 32'd0 : m_r;
    v_wdata   = (state_r == ST_CLEAR) ? 32'd0 : v_r;
    ram_raddr = AW'(in_data.param_index);
  end

  adam_ram #(.WIDTH(32), .DEPTH(NUM_PARAMS)) u_first_moment (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (m_wdata),
    .raddr (ram_raddr),
    .rdata (m_rdata)
  );

  adam_ram #(.WIDTH(32), .DEPTH(NUM_PARAMS)) u_second_moment (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (v_wdata),
    .raddr (ram_raddr),
    .rdata (v_rdata)
  );

  // Requests to the shared unit: the two bias-correction divides, then
  // all-ones over s, then the square root of that quotient.
  always_comb begin
    iter_req = '0;
    unique case (state_r)
      ST_WB: begin
        iter_req.start    = 1'b1;
        iter_req.mode     = adam_pkg::ITER_DIV;
        iter_req.dividend = {15'b0, m_abs, 16'b0};
        iter_req.divisor  = {15'b0, c_p1};
      end
      ST_MH: begin
        iter_req.start    = iter_rsp.done;
        iter_req.mode     = adam_pkg::ITER_DIV;
        iter_req.dividend = {16'b0, v_r, 16'b0};
        iter_req.divisor  = {15'b0, c_p2};
      end
      ST_S: begin
        iter_req.start    = (s_val != 32'd0);
        iter_req.mode     = adam_pkg::ITER_DIV;
        iter_req.dividend = '1;
        iter_req.divisor  = s_val;
      end
      ST_RDIV: begin
        iter_req.start    = iter_rsp.done;
        iter_req.mode     = adam_pkg::ITER_SQRT;
        iter_req.dividend = q;
      end
      default: begin
      end
    endcase
  end

  adam_iter u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (iter_req),
    .rsp   (iter_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      lr_r        <= adam_pkg::LR_RST;
      b1_r        <= adam_pkg::B1_RST;
      b2_r        <= adam_pkg::B2_RST;
      batch_r     <= adam_pkg::BATCH_RST;
      eps_r       <= adam_pkg::EPS_RST;
      bfp_r       <= adam_pkg::B1_RST;
      bsp_r       <= adam_pkg::B2_RST;
      upd_cnt_r   <= '0;
    end else begin
      // In the final state the output register is reloaded below instead.
      if (out_valid_r && !out_stall && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end

      // Writing a beta also restarts its power.
      if (cfg_wr) begin
        unique case (adam_pkg::cfg_reg_t'(cfg_index))
          adam_pkg::CFG_LEARNING_RATE: lr_r <= cfg_data;
          adam_pkg::CFG_BETA_FIRST: begin
            b1_r  <= cfg_data[15:0];
            bfp_r <= cfg_data[15:0];
          end
          adam_pkg::CFG_BETA_SECOND: begin
            b2_r  <= cfg_data[15:0];
            bsp_r <= cfg_data[15:0];
          end
          adam_pkg::CFG_BATCH_SIZE: batch_r <= cfg_data[15:0];
          adam_pkg::CFG_EPSILON:    eps_r   <= cfg_data[15:0];
          default: begin
          end
        endcase
      end

      unique case (state_r)
        ST_CLEAR: begin
          if (clr_cnt_r == AW'(NUM_PARAMS - 1)) begin
            state_r <= ST_IDLE;
          end else begin
            clr_cnt_r <= clr_cnt_r + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            idx_r      <= in_data.param_index;
            g_r        <= in_data.gradient;
            w_r        <= in_data.weight_in;
            res_r      <= in_data.weight_in;
            sat_r      <= 1'b0;
            in_range_r <= in_range;
            state_r    <= in_range ? ST_M1 : ST_OUT;
          end
        end
        ST_M1: begin
          m_old_r <= m_rdata;
          v_old_r <= v_rdata;
          pa_r    <= $signed({1'b0, c_b1}) * g_r;
          state_r <= ST_M2;
        end
        ST_M2: begin
          pb_r    <= $signed({1'b0, b1_r}) * m_old_r;
          state_r <= ST_M3;
        end
        ST_M3: begin
          m_r     <= m_sat[31:0];
          sat_r   <= sat_r | m_sat[32];
          pa_r    <= g_r * g_r;
          state_r <= ST_M4;
        end
        ST_M4: begin
          if (|pa_r[65:48]) begin
            gsq_r <= 32'hFFFF_FFFF;
            sat_r <= 1'b1;
          end else begin
            gsq_r <= pa_r[47:16];
          end
          state_r <= ST_M5;
        end
        ST_M5: begin
          pa_r    <= $signed({1'b0, c_b2}) * $signed({1'b0, gsq_r});
          state_r <= ST_M6;
        end
        ST_M6: begin
          pb_r    <= $signed({1'b0, b2_r}) * $signed({1'b0, v_old_r});
          state_r <= ST_M7;
        end
        ST_M7: begin
          if (|pab_sum[65:48]) begin
            v_r   <= 32'hFFFF_FFFF;
            sat_r <= 1'b1;
          end else begin
            v_r <= pab_sum[47:16];
          end
          state_r <= ST_WB;
        end
        ST_WB: begin
          state_r <= ST_MH;
        end
        ST_MH: begin
          // Quotient is the magnitude; truncation toward zero keeps its sign.
          if (iter_rsp.done) begin
            if (m_r[31]) begin
              if (q > 64'h8000_0000) begin
                mh_r  <= adam_pkg::S32_MIN;
                sat_r <= 1'b1;
              end else begin
                mh_r <= q_neg;
              end
            end else if (q > 64'h7FFF_FFFF) begin
              mh_r  <= adam_pkg::S32_MAX;
              sat_r <= 1'b1;
            end else begin
              mh_r <= q[31:0];
            end
            state_r <= ST_VH;
          end
        end
        ST_VH: begin
          if (iter_rsp.done) begin
            if (|q[63:32]) begin
              vh_r  <= 32'hFFFF_FFFF;
              sat_r <= 1'b1;
            end else begin
              vh_r <= q[31:0];
            end
            state_r <= ST_S;
          end
        end
        ST_S: begin
          if (s_sum[32]) begin
            sat_r <= 1'b1;
          end
          // A zero sum has no root; the largest value stands in for it.
          if (s_val == 32'd0) begin
            r_r     <= 32'hFFFF_FFFF;
            sat_r   <= 1'b1;
            state_r <= ST_T;
          end else begin
            state_r <= ST_RDIV;
          end
        end
        ST_RDIV: begin
          if (iter_rsp.done) begin
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (iter_rsp.done) begin
            r_r     <= q[31:0];
            state_r <= ST_T;
          end
        end
        ST_T: begin
          t_r     <= t_prod[55:24];
          state_r <= ST_D;
        end
        ST_D: begin
          pa_r    <= $signed(mh_r) * $signed({1'b0, t_r});
          state_r <= ST_RES;
        end
        ST_RES: begin
          res_r   <= res_sat[31:0];
          sat_r   <= sat_r | res_sat[32];
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r.out_index  <= idx_r;
            out_data_r.weight_out <= res_r;
            out_data_r.saturated  <= sat_r;
            out_valid_r           <= 1'b1;
            state_r               <= ST_IDLE;
            // Bias-correction step count; a batch size of zero acts as one.
            if (in_range_r) begin
              if (cnt_inc >= batch_r) begin
                upd_cnt_r <= '0;
                bfp_r     <= bfp_prod[31:16];
                bsp_r     <= bsp_prod[31:16];
              end else begin
                upd_cnt_r <= cnt_inc;
              end
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `ADAM_ASSERT_NEXT(a_accept_blocks_next, in_acc, in_stall,
                    "top: a second beat could follow an accepted one at once")
  `ADAM_ASSERT_IMPL(a_iter_start_free, iter_req.start, !iter_rsp.busy,
                    "top: iterative unit started while busy")
  `ADAM_ASSERT_IMPL(a_iter_done_awaited, iter_rsp.done,
                    state_r == ST_MH || state_r == ST_VH || state_r == ST_RDIV ||
                    state_r == ST_SQRT,
                    "top: iterative result arrived with nobody waiting")

endmodule

`default_nettype wire

@@ rtl/adam_ram.sv @@
// ----------------------------------------------------------------------------
// adam_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module adam_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/adam_iter.sv @@
// ----------------------------------------------------------------------------
// adam_iter
// Shared iterative unit: 64/32 restoring divide, one quotient bit per cycle,
// or 64-bit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adam_optimizer_update_assert.svh"

module adam_iter (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire adam_pkg::iter_req_t  req,
  output adam_pkg::iter_rsp_t       rsp
);

  logic                 busy_r;
  logic                 done_r;
  adam_pkg::iter_mode_t mode_r;
  logic [6:0]           cnt_r;
  logic [63:0]          acc_r;
  logic [34:0]          rem_r;
  logic [31:0]          root_r;
  logic [31:0]          div_r;

  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic        ge;
  logic [34:0] rem_nxt;
  logic [63:0] acc_nxt;
  logic [31:0] root_nxt;

  always_comb begin
    unique case (mode_r)
      adam_pkg::ITER_DIV: begin
        rem_sh = {rem_r[33:0], acc_r[63]};
        trial  = {3'b000, div_r};
      end
      adam_pkg::ITER_SQRT: begin
        rem_sh = {rem_r[32:0], acc_r[63:62]};
        trial  = {1'b0, root_r, 2'b01};
      end
      default: begin
        rem_sh = rem_r;
        trial  = '0;
      end
    endcase
    ge      = (rem_sh >= trial);
    rem_nxt = ge ? (rem_sh - trial) : rem_sh;
    if (mode_r == adam_pkg::ITER_DIV) begin
      acc_nxt = {acc_r[62:0], ge};
    end else begin
      acc_nxt = {acc_r[61:0], 2'b00};
    end
    root_nxt = {root_r[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        mode_r <= req.mode;
        acc_r  <= req.dividend;
        div_r  <= req.divisor;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= (req.mode == adam_pkg::ITER_DIV) ? adam_pkg::ITER_DIV_STEPS - 7'd1
                                                     : adam_pkg::ITER_SQRT_STEPS - 7'd1;
      end else if (busy_r) begin
        acc_r  <= acc_nxt;
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        cnt_r  <= cnt_r - 7'd1;
        if (cnt_r == 7'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy   = busy_r;
  assign rsp.done   = done_r;
  assign rsp.result = (mode_r == adam_pkg::ITER_DIV) ? acc_r : {32'b0, root_r};

  `ADAM_ASSERT_NEXT(a_start_sets_busy, req.start, busy_r, "iter: start did not raise busy")
  `ADAM_ASSERT_NEXT(a_last_step_done, busy_r && !req.start && cnt_r == 7'd0, done_r,
                    "iter: last step gave no done")
  `ADAM_ASSERT_IMPL(a_done_after_busy, done_r, $past(busy_r) && !busy_r,
                    "iter: done without a finished run")

endmodule

`default_nettype wire

@@ tb/sv/adam_optimizer_update_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Adam update block testbench
// Streams parameter beats through the block under several register settings
// and checks every returned weight and saturation flag against a cycle-free
// fixed-point model of the update that keeps its own moment stores and powers.
// ----------------------------------------------------------------------------
`default_nettype none

module adam_optimizer_update_test;

  localparam int NPARAM     = adam_pkg::NUM_PARAMS_DEF;
  localparam int CYCLE_MAX  = 4000000;
  localparam int DRAIN_GAP  = 300;
  localparam int PHASE_BEATS = 150;

  logic                               clk;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_stall;
  adam_pkg::in_item_t                 in_data;
  logic                               out_valid;
  logic                               out_stall;
  adam_pkg::out_item_t                out_data;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [adam_pkg::CFG_IDX_W-1:0]     cfg_index;
  logic [adam_pkg::CFG_DATA_W-1:0]    cfg_data;

  adam_optimizer_update dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: a private copy of the moment stores, powers and registers.
  logic signed [31:0] first_mom [NPARAM];
  bit [31:0]          second_mom [NPARAM];
  bit [15:0]          pow_first, pow_second, upd_count;
  bit [23:0]          lr_reg;
  bit [15:0]          b1_reg, b2_reg, batch_reg, eps_reg;

  adam_pkg::in_item_t  pending_beats [$];
  adam_pkg::out_item_t expected_weights [$];

  int send_idle_pct, recv_idle_pct;
  int long_hold_cycles;
  bit in_took;
  int beats_sent, weights_checked, mismatches, sat_seen, zero_root_seen;
  int cycle_count;

  // --------------------------------------------------------------------------
  // Fixed-point helpers. Saturation sets the flag passed in.
  // --------------------------------------------------------------------------
  function automatic longint clamp_signed32(logic signed [95:0] x, inout bit f);
    if (x > 96'sd2147483647) begin
      f = 1'b1;
      return 64'sd2147483647;
    end
    if (x < -96'sd2147483648) begin
      f = 1'b1;
      return -64'sd2147483648;
    end
    return longint'(x);
  endfunction

  function automatic bit [63:0] clamp_unsigned32(bit [63:0] x, inout bit f);
    if (x > 64'hFFFF_FFFF) begin
      f = 1'b1;
      return 64'hFFFF_FFFF;
    end
    return x;
  endfunction

  function automatic bit [63:0] int_sqrt64(bit [63:0] x);
    bit [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // One Adam step: updates the moment copy and powers, returns the new weight.
  function automatic adam_pkg::out_item_t adam_weight_step(adam_pkg::in_item_t it);
    longint              g, w, m, mh;
    bit [63:0]           gsq, v, vh, s, r, t;
    logic signed [95:0]  prod, diff;
    bit                  sat;
    int                  idx;
    bit [16:0]           nxt;
    adam_pkg::out_item_t o;
    idx = int'(it.param_index);
    g = longint'(it.gradient);
    w = longint'(it.weight_in);
    sat = 1'b0;
    o.out_index = it.param_index;
    // Moments: exponential averages of the gradient and its square.
    m = ((65536 - longint'(b1_reg)) * g + longint'(b1_reg) * longint'(first_mom[idx])) >>> 16;
    m = clamp_signed32(m, sat);
    first_mom[idx] = m[31:0];
    gsq = clamp_unsigned32(64'(g * g) >> 16, sat);
    v = ((64'd65536 - b2_reg) * gsq + 64'(b2_reg) * second_mom[idx]) >> 16;
    v = clamp_unsigned32(v, sat);
    second_mom[idx] = v[31:0];
    // Bias correction by the running powers, signed divide truncates.
    mh = (m * 65536) / (65536 - longint'(pow_first));
    mh = clamp_signed32(mh, sat);
    vh = clamp_unsigned32((v << 16) / (64'd65536 - pow_second), sat);
    s = clamp_unsigned32(vh + eps_reg, sat);
    if (s == 0) begin
      r = 64'hFFFF_FFFF;
      sat = 1'b1;
    end else begin
      r = int_sqrt64(64'hFFFF_FFFF_FFFF_FFFF / s);
    end
    t = (64'(lr_reg) * r) >> 24;
    prod = 96'(mh);
    prod = prod * $signed({32'd0, t});
    diff = 96'(w);
    diff = diff - (prod >>> 24);
    o.weight_out = 32'(clamp_signed32(diff, sat));
    o.saturated = sat;
    // A batch size of zero advances the powers on every update, like one.
    nxt = {1'b0, upd_count} + 17'd1;
    if (nxt[15:0] >= batch_reg) begin
      upd_count = 0;
      pow_first = 16'((32'(pow_first) * b1_reg) >> 16);
      pow_second = 16'((32'(pow_second) * b2_reg) >> 16);
    end else begin
      upd_count = nxt[15:0];
    end
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Clock and cycle limit.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_MAX) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Input driver. A new beat is offered at the falling edge only when the
  // previous one was taken, so a stalled payload never changes.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= pending_beats.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random idling, or one long hold-off counted down here.
  always @(negedge clk) begin
    if (long_hold_cycles > 0) begin
      out_stall <= 1'b1;
      long_hold_cycles <= long_hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Each accepted input beat is predicted at the edge that takes it.
  always @(posedge clk) begin
    in_took = in_valid && !in_stall && rst_n;
    if (in_took) begin
      expected_weights.push_back(adam_weight_step(in_data));
      beats_sent++;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    adam_pkg::out_item_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_weights.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: index %0d weight %0h sat %0b",
                   out_data.out_index, out_data.weight_out, out_data.saturated);
      end else begin
        exp_w = expected_weights.pop_front();
        weights_checked++;
        if (exp_w.saturated) sat_seen++;
        if (out_data.out_index !== exp_w.out_index ||
            out_data.weight_out !== exp_w.weight_out ||
            out_data.saturated !== exp_w.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: index %0d/%0d weight %0h/%0h sat %0b/%0b (exp/act)",
                     exp_w.out_index, out_data.out_index, exp_w.weight_out,
                     out_data.weight_out, exp_w.saturated, out_data.saturated);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus control.
  // --------------------------------------------------------------------------
  task automatic reg_write(adam_pkg::cfg_reg_t r, bit [23:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = r;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (r)
      adam_pkg::CFG_LEARNING_RATE: lr_reg = val;
      adam_pkg::CFG_BETA_FIRST: begin
        b1_reg = val[15:0];
        pow_first = val[15:0];
      end
      adam_pkg::CFG_BETA_SECOND: begin
        b2_reg = val[15:0];
        pow_second = val[15:0];
      end
      adam_pkg::CFG_BATCH_SIZE: batch_reg = val[15:0];
      adam_pkg::CFG_EPSILON: eps_reg = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all(bit [23:0] lr, bit [15:0] b1, bit [15:0] b2,
                           bit [15:0] bs, bit [15:0] ep);
    reg_write(adam_pkg::CFG_LEARNING_RATE, lr);
    reg_write(adam_pkg::CFG_BETA_FIRST, 24'(b1));
    reg_write(adam_pkg::CFG_BETA_SECOND, 24'(b2));
    reg_write(adam_pkg::CFG_BATCH_SIZE, 24'(bs));
    reg_write(adam_pkg::CFG_EPSILON, 24'(ep));
  endtask

  // Wait until every result is back, then let the block settle.
  task automatic drain;
    wait (pending_beats.size() == 0 && !in_valid && expected_weights.size() == 0);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic add_beat(int idx, int g, int w);
    adam_pkg::in_item_t it;
    it.param_index = idx[11:0];
    it.gradient = g;
    it.weight_in = w;
    pending_beats.push_back(it);
  endtask

  // Most random beats revisit a small index set so moments build up; indexes
  // above 4000 stay untouched for the zero-root beats.
  task automatic add_random_beats(int n);
    int idx, g;
    repeat (n) begin
      case ($urandom_range(9))
        0, 1:    idx = $urandom_range(4000);
        default: idx = $urandom_range(31);
      endcase
      case ($urandom_range(9))
        0:       g = $urandom;
        1, 2:    g = $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
        default: g = $signed($urandom_range(32'h0003_FFFF)) - 32'sh0002_0000;
      endcase
      add_beat(idx, g, $urandom);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = adam_pkg::CFG_LEARNING_RATE;
    cfg_data = '0;
    in_took = 1'b0;
    long_hold_cycles = 0;
    send_idle_pct = 37;
    recv_idle_pct = 85;
    beats_sent = 0;
    weights_checked = 0;
    mismatches = 0;
    sat_seen = 0;
    zero_root_seen = 0;
    cycle_count = 0;
    foreach (first_mom[i]) first_mom[i] = '0;
    foreach (second_mom[i]) second_mom[i] = '0;
    lr_reg = adam_pkg::LR_RST;
    b1_reg = adam_pkg::B1_RST;
    b2_reg = adam_pkg::B2_RST;
    batch_reg = adam_pkg::BATCH_RST;
    eps_reg = adam_pkg::EPS_RST;
    pow_first = adam_pkg::B1_RST;
    pow_second = adam_pkg::B2_RST;
    upd_count = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed beats under the reset settings: field extremes and repeated
    // indexes so the moments and powers move.
    add_beat(0, 0, 0);
    add_beat(4095, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    add_beat(4095, 32'sh8000_0000, 32'sh8000_0000);
    add_beat(1, 1, -1);
    add_beat(1, -1, 1);
    add_beat(2, 32'sh0001_0000, 32'sh0001_0000);
    add_beat(2, 32'sh0001_0000, 32'sh7FFF_FFF0);
    add_beat(2, -32'sh0001_0000, 32'sh8000_0010);
    add_beat(2730, 32'sh5555_5555, 32'shAAAA_AAAA);
    add_beat(1365, 32'shAAAA_AAAA, 32'sh5555_5555);
    add_beat(3, 32'sh0000_8000, 0);
    add_beat(3, 32'sh0000_8000, 0);
    add_beat(3, 32'sh0000_8000, 0);
    drain();

    // Zero root: no epsilon, no second-moment memory, zero or tiny gradients on
    // fresh indexes, with the largest step size, then one large gradient.
    write_all(24'hFF_FFFF, 16'd0, 16'd0, 16'd0, 16'd0);
    add_beat(4001, 0, 32'sh1234_5678);
    add_beat(4002, 255, 0);
    add_beat(4003, -200, 0);
    add_beat(5, 32'sh0010_0000, 0);
    zero_root_seen += 3;
    drain();

    // Sender pause until every result has come, with the long receiver
    // hold-off while beats keep being offered.
    write_all(24'd16777, 16'd58982, 16'd65470, 16'd1, 16'd1);
    add_random_beats(PHASE_BEATS);
    long_hold_cycles = 3000;
    drain();

    write_all(24'hFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_random_beats(PHASE_BEATS);
    drain();
    write_all(24'h00_0000, 16'h0000, 16'h0000, 16'd1, 16'h0000);
    add_random_beats(PHASE_BEATS);
    drain();

    send_idle_pct = 85;
    recv_idle_pct = 37;
    write_all(24'h08_0000, 16'd52429, 16'd65404, 16'd3, 16'd16);
    add_random_beats(PHASE_BEATS);
    drain();
    write_all(24'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(1, 8)),
              16'($urandom));
    add_random_beats(PHASE_BEATS);
    drain();
    write_all(24'h00_4000, 16'd32768, 16'd65535, 16'd0, 16'd1);
    add_random_beats(PHASE_BEATS);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_all(24'd16777, 16'd58982, 16'd65470, 16'd2, 16'd1);
    add_random_beats(PHASE_BEATS);
    drain();
    write_all(24'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(1, 4)),
              16'($urandom_range(255)));
    add_random_beats(PHASE_BEATS);
    drain();
    write_all(24'hFF_FFFF, 16'd58982, 16'd65470, 16'd1, 16'd0);
    add_random_beats(PHASE_BEATS);
    drain();

    $display("covered %0d beats, %0d results checked, %0d saturated, %0d zero-root",
             beats_sent, weights_checked, sat_seen, zero_root_seen);
    $display("register settings ranged from near-zero to all-ones across 11 phases");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("mismatching beats: %0d", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+rtl
rtl/adam_pkg.sv
rtl/adam_ram.sv
rtl/adam_iter.sv
rtl/adam_optimizer_update.sv
tb/sv/adam_optimizer_update_test.sv
